// ===== rtl/lsd_radix_sort_decimal_assert.svh =====
// Assertion helpers used by the sorter's back end module.
// Each module that uses them names its clock clk_i and its reset rst_ni.
`ifndef LSD_RADIX_SORT_DECIMAL_ASSERT_SVH
`define LSD_RADIX_SORT_DECIMAL_ASSERT_SVH

// Clocked property, off while reset is asserted.
`define LSD_RSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lsd_rsd: assertion failed");

// Condition that must never be seen at a clock edge.
`define LSD_RSD_NEVER(lbl, cond) `LSD_RSD_ASSERT(lbl, !(cond))

`endif

// ===== rtl/lsd_rsd_pkg.sv =====
package lsd_rsd_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int DIGITS      = 10;
  localparam int TAG_BITS    = 16;

  localparam int KEY_W       = 34;
  localparam int TAG_W       = 16;
  // decimal digits needed to hold any 34-bit key
  localparam int BCD_DIGITS  = 11;
  localparam int SORT_DIGITS = (DIGITS < BCD_DIGITS) ? DIGITS : BCD_DIGITS;
  localparam int DIG_W       = 4 * SORT_DIGITS;
  localparam int BCD_W       = 4 * BCD_DIGITS;
  localparam int STORE_TAG_W = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam int NUM_BINS    = 10;

  localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
  localparam int ADDR_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int PASS_W = (SORT_DIGITS > 1) ? $clog2(SORT_DIGITS) : 1;

  // binary to decimal conversion, key bits shifted in per cycle
  localparam int DAB_BITS  = 2;
  localparam int DAB_STEPS = (KEY_W + DAB_BITS - 1) / DAB_BITS;
  localparam int STEP_W    = (DAB_STEPS > 1) ? $clog2(DAB_STEPS) : 1;
  localparam int SH_W      = DAB_STEPS * DAB_BITS;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  typedef logic [KEY_W-1:0]       key_t;
  typedef logic [TAG_W-1:0]       tag_t;
  typedef logic [STORE_TAG_W-1:0] stag_t;
  typedef logic [DIG_W-1:0]       digits_t;
  typedef logic [BCD_W-1:0]       bcd_t;
  typedef logic [SH_W-1:0]        sh_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [PASS_W-1:0]      pass_t;
  typedef logic [STEP_W-1:0]      step_t;
  typedef logic [3:0]             digit_t;

  typedef struct packed {
    key_t    key;
    stag_t   tag;
    digits_t digits;
  } rec_t;

  typedef struct packed {
    key_t    key;
    stag_t   tag;
    digits_t digits;
    logic    last;
  } entry_t;

endpackage

// ===== rtl/lsd_rsd_in_if.sv =====
interface lsd_rsd_in_if;
  logic               valid;
  logic               ready;
  lsd_rsd_pkg::key_t  sort_key;
  lsd_rsd_pkg::tag_t  payload_tag;
  logic               last_item;

  modport source(output valid, sort_key, payload_tag, last_item, input ready);
  modport sink(input valid, sort_key, payload_tag, last_item, output ready);
endinterface

// ===== rtl/lsd_rsd_out_if.sv =====
interface lsd_rsd_out_if;
  logic               valid;
  logic               ready;
  lsd_rsd_pkg::key_t  sorted_key;
  lsd_rsd_pkg::tag_t  sorted_tag;
  logic               last_result;
  logic               records_dropped;

  modport source(output valid, sorted_key, sorted_tag, last_result, records_dropped,
                 input ready);
  modport sink(input valid, sorted_key, sorted_tag, last_result, records_dropped,
               output ready);
endinterface

// ===== rtl/lsd_rsd_front.sv =====
module lsd_rsd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  lsd_rsd_in_if.sink           in_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output lsd_rsd_pkg::entry_t  push_data_o
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_CONV = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]              st_q, st_d;
  lsd_rsd_pkg::step_t      step_q, step_d;
  lsd_rsd_pkg::sh_t        sh_q, sh_d;
  lsd_rsd_pkg::bcd_t       bcd_q, bcd_d;
  lsd_rsd_pkg::key_t       key_q;
  lsd_rsd_pkg::stag_t      tag_q;
  logic                    last_q;
  logic                    take;

  // one double-dabble step: adjust each decimal digit, then shift one key bit in
  function automatic lsd_rsd_pkg::bcd_t dabble(lsd_rsd_pkg::bcd_t b, logic bit_in);
    lsd_rsd_pkg::bcd_t a;
    a = b;
    for (int i = 0; i < lsd_rsd_pkg::BCD_DIGITS; i++) begin
      if (b[4*i +: 4] >= 4'd5) begin
        a[4*i +: 4] = b[4*i +: 4] + 4'd3;
      end
    end
    return {a[lsd_rsd_pkg::BCD_W-2:0], bit_in};
  endfunction

  assign in_i.ready   = (st_q == F_IDLE);
  assign take         = in_i.valid && in_i.ready;
  assign push_valid_o = (st_q == F_PUSH);
  assign push_data_o  = '{key: key_q, tag: tag_q,
                          digits: bcd_q[lsd_rsd_pkg::DIG_W-1:0], last: last_q};

  always_comb begin
    lsd_rsd_pkg::bcd_t b;
    st_d   = st_q;
    step_d = step_q;
    sh_d   = sh_q;
    bcd_d  = bcd_q;
    b      = bcd_q;
    case (st_q)
      F_IDLE: begin
        if (take) begin
          st_d   = F_CONV;
          step_d = '0;
          sh_d   = lsd_rsd_pkg::sh_t'(in_i.sort_key);
          bcd_d  = '0;
        end
      end
      F_CONV: begin
        for (int j = 0; j < lsd_rsd_pkg::DAB_BITS; j++) begin
          b = dabble(b, sh_q[lsd_rsd_pkg::SH_W-1-j]);
        end
        bcd_d  = b;
        sh_d   = sh_q << lsd_rsd_pkg::DAB_BITS;
        step_d = step_q + 1'b1;
        if (step_q == lsd_rsd_pkg::step_t'(lsd_rsd_pkg::DAB_STEPS - 1)) begin
          st_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready_i) begin
          st_d = F_IDLE;
        end
      end
      default: st_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= F_IDLE;
      step_q <= '0;
    end else begin
      st_q   <= st_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    bcd_q <= bcd_d;
    if (take) begin
      key_q  <= in_i.sort_key;
      tag_q  <= in_i.payload_tag[lsd_rsd_pkg::STORE_TAG_W-1:0];
      last_q <= in_i.last_item;
    end
  end

endmodule

// ===== rtl/lsd_rsd_fifo.sv =====
module lsd_rsd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  lsd_rsd_pkg::entry_t  push_data_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output lsd_rsd_pkg::entry_t  pop_data_o
);

  lsd_rsd_pkg::entry_t                  slots_q [lsd_rsd_pkg::FIFO_DEPTH];
  logic [lsd_rsd_pkg::FIFO_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [lsd_rsd_pkg::FIFO_PTR_W:0]     fill_q;
  logic                                 push, pop;

  assign push_ready_o = (fill_q != (lsd_rsd_pkg::FIFO_PTR_W + 1)'(lsd_rsd_pkg::FIFO_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/lsd_rsd_back.sv =====
`include "lsd_radix_sort_decimal_assert.svh"

module lsd_rsd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  lsd_rsd_pkg::entry_t  pop_data_i,
  lsd_rsd_out_if.source        out_o
);

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_COUNT  = 3'd1;
  localparam logic [2:0] S_PREFIX = 3'd2;
  localparam logic [2:0] S_SCAT   = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0]           st_q, st_d;
  lsd_rsd_pkg::cnt_t    cnt_q, cnt_d;
  logic                 ovf_q, ovf_d;
  lsd_rsd_pkg::pass_t   pass_q, pass_d;
  logic                 sel_q, sel_d;
  lsd_rsd_pkg::cnt_t    idx_q, idx_d;
  logic                 rv_q, rv_d;
  lsd_rsd_pkg::digit_t  pidx_q, pidx_d;
  lsd_rsd_pkg::cnt_t    acc_q, acc_d;
  lsd_rsd_pkg::cnt_t    bins_q [lsd_rsd_pkg::NUM_BINS];
  lsd_rsd_pkg::cnt_t    bins_d [lsd_rsd_pkg::NUM_BINS];
  logic                 pend_q, pend_d;
  logic                 plast_q, plast_d;
  logic                 out_valid_q;
  lsd_rsd_pkg::key_t    okey_q;
  lsd_rsd_pkg::stag_t   otag_q;
  logic                 olast_q, odrop_q;

  // ping-pong record stores: loads go to A, each pass moves records across
  lsd_rsd_pkg::rec_t    mem_a [lsd_rsd_pkg::MAX_RECORDS];
  lsd_rsd_pkg::rec_t    mem_b [lsd_rsd_pkg::MAX_RECORDS];
  lsd_rsd_pkg::rec_t    rd_a_q, rd_b_q, rec_rd, wr_rec;
  lsd_rsd_pkg::addr_t   rd_addr, wr_addr;
  logic                 wr_a_en, wr_b_en;

  logic                 pop_fire;
  lsd_rsd_pkg::digit_t  dig;
  lsd_rsd_pkg::cnt_t    slot, idx_m1, cnt_m1;

  assign pop_ready_o = (st_q == S_LOAD);
  assign pop_fire    = pop_valid_i && pop_ready_o;
  assign rec_rd      = sel_q ? rd_b_q : rd_a_q;
  assign dig         = rec_rd.digits[pass_q * 4 +: 4];
  assign slot        = bins_q[dig] - 1'b1;
  assign idx_m1      = idx_q - 1'b1;
  assign cnt_m1      = cnt_q - 1'b1;

  assign out_o.valid           = out_valid_q;
  assign out_o.sorted_key      = okey_q;
  assign out_o.sorted_tag      = lsd_rsd_pkg::tag_t'(otag_q);
  assign out_o.last_result     = olast_q;
  assign out_o.records_dropped = odrop_q;

  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    pass_d  = pass_q;
    sel_d   = sel_q;
    idx_d   = idx_q;
    rv_d    = 1'b0;
    pidx_d  = pidx_q;
    acc_d   = acc_q;
    bins_d  = bins_q;
    pend_d  = pend_q;
    plast_d = plast_q;
    rd_addr = idx_q[lsd_rsd_pkg::ADDR_W-1:0];
    wr_addr = cnt_q[lsd_rsd_pkg::ADDR_W-1:0];
    wr_rec  = '{key: pop_data_i.key, tag: pop_data_i.tag, digits: pop_data_i.digits};
    wr_a_en = 1'b0;
    wr_b_en = 1'b0;
    case (st_q)
      S_LOAD: begin
        if (pop_fire) begin
          if (cnt_q < lsd_rsd_pkg::cnt_t'(lsd_rsd_pkg::MAX_RECORDS)) begin
            wr_a_en = 1'b1;
            cnt_d   = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (pop_data_i.last) begin
            st_d   = S_COUNT;
            pass_d = '0;
            sel_d  = 1'b0;
            idx_d  = '0;
            for (int i = 0; i < lsd_rsd_pkg::NUM_BINS; i++) begin
              bins_d[i] = '0;
            end
          end
        end
      end
      S_COUNT: begin
        if (rv_q) begin
          bins_d[dig] = bins_q[dig] + 1'b1;
        end
        if (idx_q != cnt_q) begin
          rv_d  = 1'b1;
          idx_d = idx_q + 1'b1;
        end else begin
          st_d   = S_PREFIX;
          pidx_d = '0;
          acc_d  = '0;
        end
      end
      S_PREFIX: begin
        // turn counts into running end positions, one bin a cycle
        acc_d          = acc_q + bins_q[pidx_q];
        bins_d[pidx_q] = acc_d;
        pidx_d         = pidx_q + 1'b1;
        if (pidx_q == lsd_rsd_pkg::digit_t'(lsd_rsd_pkg::NUM_BINS - 1)) begin
          st_d  = S_SCAT;
          idx_d = cnt_q;
        end
      end
      S_SCAT: begin
        // walk from the back so equal digits keep their order
        if (rv_q) begin
          bins_d[dig] = slot;
          wr_addr     = slot[lsd_rsd_pkg::ADDR_W-1:0];
          wr_rec      = rec_rd;
          wr_a_en     = sel_q;
          wr_b_en     = !sel_q;
        end
        if (idx_q != '0) begin
          rd_addr = idx_m1[lsd_rsd_pkg::ADDR_W-1:0];
          idx_d   = idx_m1;
          rv_d    = 1'b1;
        end else begin
          sel_d = !sel_q;
          idx_d = '0;
          if (pass_q == lsd_rsd_pkg::pass_t'(lsd_rsd_pkg::SORT_DIGITS - 1)) begin
            st_d   = S_EMIT;
            pend_d = 1'b0;
          end else begin
            st_d   = S_COUNT;
            pass_d = pass_q + 1'b1;
            for (int i = 0; i < lsd_rsd_pkg::NUM_BINS; i++) begin
              bins_d[i] = '0;
            end
          end
        end
      end
      S_EMIT: begin
        if (pend_q) begin
          pend_d = 1'b0;
          if (plast_q) begin
            st_d  = S_LOAD;
            cnt_d = '0;
            ovf_d = 1'b0;
          end
        end else if ((idx_q != cnt_q) && (!out_valid_q || out_o.ready)) begin
          idx_d   = idx_q + 1'b1;
          pend_d  = 1'b1;
          plast_d = (idx_q == cnt_m1);
        end
      end
      default: st_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_LOAD;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      pass_q      <= '0;
      sel_q       <= 1'b0;
      idx_q       <= '0;
      rv_q        <= 1'b0;
      pidx_q      <= '0;
      acc_q       <= '0;
      pend_q      <= 1'b0;
      plast_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < lsd_rsd_pkg::NUM_BINS; i++) begin
        bins_q[i] <= '0;
      end
    end else begin
      st_q    <= st_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      pass_q  <= pass_d;
      sel_q   <= sel_d;
      idx_q   <= idx_d;
      rv_q    <= rv_d;
      pidx_q  <= pidx_d;
      acc_q   <= acc_d;
      pend_q  <= pend_d;
      plast_q <= plast_d;
      bins_q  <= bins_d;
      if (pend_q) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the result until taken; a new one only lands when the register is free
  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      okey_q  <= rec_rd.key;
      otag_q  <= rec_rd.tag;
      olast_q <= plast_q;
      odrop_q <= ovf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_a_en) begin
      mem_a[wr_addr] <= wr_rec;
    end
    rd_a_q <= mem_a[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_b_en) begin
      mem_b[wr_addr] <= wr_rec;
    end
    rd_b_q <= mem_b[rd_addr];
  end

  `LSD_RSD_ASSERT(a_cnt_bound, cnt_q <= lsd_rsd_pkg::cnt_t'(lsd_rsd_pkg::MAX_RECORDS))
  `LSD_RSD_ASSERT(a_ovf_full, ovf_q |-> (cnt_q == lsd_rsd_pkg::cnt_t'(lsd_rsd_pkg::MAX_RECORDS)))
  `LSD_RSD_ASSERT(a_bin_nonzero, (st_q == S_SCAT && rv_q) |-> (bins_q[dig] != '0))
  `LSD_RSD_ASSERT(a_out_from_read, $rose(out_valid_q) |-> $past(pend_q))
  `LSD_RSD_ASSERT(a_pend_emit, pend_q |-> (st_q == S_EMIT))

endmodule

// ===== rtl/lsd_radix_sort_decimal.sv =====
// Stable decimal LSD radix sorter for sets of up to MAX_RECORDS records.
// in_i: valid/ready channel of records (sort_key, payload_tag, last_item).
//   Records are loaded until one has last_item set; that record closes the set
//   and starts the sort. Records that find the store full are dropped.
// out_o: valid/ready channel of the sorted set in ascending order of the keys'
//   low ten decimal digits, one item per stored record; last_result marks the
//   final item and records_dropped is set on every item of a set that lost records.
// Front: accepts a record, converts its key to decimal digits and queues it, and
//   takes no new record until then; the back stores one per cycle while loading and the queue is not empty.
// Sort: one counting pass per digit, each a count walk, a ten-step prefix and a
//   back-to-front scatter walk, paced by the single read port of each record
//   store. Emission reads each item from the store before it starts the next.
// The front keeps converting and queueing the next set's records while the
//   back sorts; input stalls once the two-entry queue is full and the front holds a converted record.
// A stalled receiver holds the current result in the output register and the
//   read-out waits; nothing is lost.
// Reset empties the queue, clears the record count and the drop flag; the
//   record stores hold no valid data until loaded.
module lsd_radix_sort_decimal (
  input  logic           clk_i,
  input  logic           rst_ni,
  lsd_rsd_in_if.sink     in_i,
  lsd_rsd_out_if.source  out_o
);

  logic                 f_valid, f_ready;
  lsd_rsd_pkg::entry_t  f_data;
  logic                 q_valid, q_ready;
  lsd_rsd_pkg::entry_t  q_data;

  lsd_rsd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (f_valid),
    .push_ready_i (f_ready),
    .push_data_o  (f_data)
  );

  lsd_rsd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_data),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  lsd_rsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_valid),
    .pop_ready_o (q_ready),
    .pop_data_i  (q_data),
    .out_o       (out_o)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  typedef lsd_rsd_pkg::key_t  key_t;
  typedef lsd_rsd_pkg::tag_t  tag_t;
  typedef lsd_rsd_pkg::stag_t stag_t;

  localparam int HOLD_OFF_CYCLES = 3000;
  localparam int TOTAL_ITEMS     = 330;
  localparam int CALM_AFTER      = 280;
  localparam int DRAIN_CYCLES    = 200;
  localparam int NUM_DIRECTED    = 21;
  localparam longint unsigned DEC_SPAN = 64'd10 ** lsd_rsd_pkg::DIGITS;

  typedef struct packed {
    key_t key;
    tag_t tag;
  } record_t;

  typedef struct packed {
    key_t key;
    tag_t tag;
    logic last_result;
    logic dropped;
  } sorted_rec_t;

  typedef struct packed {
    key_t key;
    tag_t tag;
    logic last;
    logic typed;
    key_t exp_key;
    tag_t exp_tag;
  } dir_row_t;

  // single-record sets carry their result; the rest go through the predictor
  localparam dir_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{34'd0,           16'h0000, 1'b1, 1'b1, 34'd0,           16'h0000},
    '{34'h3_FFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 34'h3_FFFF_FFFF, 16'hFFFF},
    '{34'd9999999999,  16'h5A5A, 1'b1, 1'b1, 34'd9999999999,  16'h5A5A},
    '{34'd10000000005, 16'h0001, 1'b0, 1'b0, 34'd0, 16'h0000},
    '{34'd5,           16'h0002, 1'b0, 1'b0, 34'd0, 16'h0000},
    '{34'd17179869183, 16'h0003, 1'b0, 1'b0, 34'd0, 16'h0000},
    '{34'd7179869183,  16'h0004, 1'b0, 1'b0, 34'd0, 16'h0000},
    '{34'd0,           16'h8000, 1'b0, 1'b0, 34'd0, 16'h0000},
    '{34'd9999999999,  16'h0006, 1'b1, 1'b0, 34'd0, 16'h0000},
    '{34'd9,           16'h0109, 1'b0, 1'b0, 34'd0, 16'h0000},
    '{34'd8,           16'h0108, 1'b0, 1'b0, 34'd0, 16'h0000},
    '{34'd7,           16'h0107, 1'b0, 1'b0, 34'd0, 16'h0000},
    '{34'd6,           16'h0106, 1'b0, 1'b0, 34'd0, 16'h0000},
    '{34'd5,           16'h0105, 1'b0, 1'b0, 34'd0, 16'h0000},
    '{34'd4,           16'h0104, 1'b0, 1'b0, 34'd0, 16'h0000},
    '{34'd3,           16'h0103, 1'b0, 1'b0, 34'd0, 16'h0000},
    '{34'd2,           16'h0102, 1'b0, 1'b0, 34'd0, 16'h0000},
    '{34'd1,           16'h0101, 1'b0, 1'b0, 34'd0, 16'h0000},
    '{34'd0,           16'h0100, 1'b1, 1'b0, 34'd0, 16'h0000},
    '{34'd42,          16'hAAAA, 1'b0, 1'b0, 34'd0, 16'h0000},
    '{34'd42,          16'h5555, 1'b1, 1'b0, 34'd0, 16'h0000}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #4 clk_i = ~clk_i;

  lsd_rsd_in_if  in_bus ();
  lsd_rsd_out_if out_bus ();

  lsd_radix_sort_decimal u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  record_t     held_records [$];
  bit          held_overflow = 1'b0;
  sorted_rec_t sorted_due [$];
  int          fail_count   = 0;
  int          results_seen = 0;
  int          items_sent   = 0;
  bit          calm         = 1'b0;

  function automatic longint unsigned low_digits(key_t k);
    return 64'(k) % DEC_SPAN;
  endfunction

  // store a record; on the last one sort the set stably, queue it if predict_due
  task automatic load_record(key_t key, tag_t tag, logic last, bit predict_due);
    record_t run [$];
    record_t r;
    int      j;
    if (held_records.size() < lsd_rsd_pkg::MAX_RECORDS) begin
      held_records.insert(held_records.size(), record_t'{key, tag_t'(stag_t'(tag))});
    end else begin
      held_overflow = 1'b1;
    end
    if (!last) return;
    run = held_records;
    for (int i = 1; i < run.size(); i++) begin
      r = run[i];
      j = i;
      while (j > 0 && low_digits(run[j-1].key) > low_digits(r.key)) begin
        run[j] = run[j-1];
        j--;
      end
      run[j] = r;
    end
    if (predict_due) begin
      foreach (run[i]) begin
        sorted_due.insert(sorted_due.size(),
                          sorted_rec_t'{run[i].key, run[i].tag,
                                        logic'(i == run.size() - 1), held_overflow});
      end
    end
    held_records.delete();
    held_overflow = 1'b0;
  endtask

  task automatic drive_record(key_t key, tag_t tag, logic last, bit predict_due);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_bus.valid       <= 1'b1;
    in_bus.sort_key    <= key;
    in_bus.payload_tag <= tag;
    in_bus.last_item   <= last;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    load_record(key, tag, last, predict_due);
    items_sent++;
  endtask

  function automatic key_t pick_key();
    longint unsigned v;
    v = {$urandom(), $urandom()};
    case ($urandom_range(0, 4))
      0: return key_t'(v);
      1: return key_t'($urandom_range(0, 30));
      2: return key_t'(v % DEC_SPAN);
      3: begin
        if ($urandom_range(0, 1) == 1) return key_t'(DEC_SPAN + $urandom_range(0, 20));
        return key_t'(DEC_SPAN - 1 - $urandom_range(0, 20));
      end
      default: return key_t'(64'($urandom_range(1, 9)) * (64'd10 ** $urandom_range(0, 9)));
    endcase
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    sorted_rec_t due;
    if (rst_ni && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      results_seen++;
      if (sorted_due.size() == 0) begin
        $error("sorted_key: expected none, actual %0d", out_bus.sorted_key);
        fail_count++;
      end else begin
        due = sorted_due.pop_front();
        check_field("sorted_key", 64'(due.key), 64'(out_bus.sorted_key));
        check_field("sorted_tag", 64'(due.tag), 64'(out_bus.sorted_tag));
        check_field("last_result", 64'(due.last_result), 64'(out_bus.last_result));
        check_field("records_dropped", 64'(due.dropped), 64'(out_bus.records_dropped));
      end
    end
  end

  // receiver: random stall bursts, one long hold-off mid-run
  initial begin
    bit held_off;
    int gap;
    held_off      = 1'b0;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_off && results_seen >= 40) begin
        held_off = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk_i);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 8);
        out_bus.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    dir_row_t row;
    int       set_no;
    int       set_size;
    in_bus.valid       = 1'b0;
    in_bus.sort_key    = '0;
    in_bus.payload_tag = '0;
    in_bus.last_item   = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      drive_record(row.key, row.tag, row.last, !row.typed);
      if (row.typed) begin
        sorted_due.insert(sorted_due.size(),
                          sorted_rec_t'{row.exp_key, row.exp_tag, 1'b1, 1'b0});
      end
    end

    // open with sets that overflow, fill exactly, and drop several records
    set_no = 0;
    while (items_sent < TOTAL_ITEMS) begin
      case (set_no)
        0:       set_size = lsd_rsd_pkg::MAX_RECORDS + 1;
        1:       set_size = lsd_rsd_pkg::MAX_RECORDS;
        2:       set_size = lsd_rsd_pkg::MAX_RECORDS + 6;
        default: set_size = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40)
                                                        : $urandom_range(1, 10);
      endcase
      for (int k = 0; k < set_size; k++) begin
        drive_record(pick_key(), tag_t'($urandom()), logic'(k == set_size - 1), 1'b1);
        if (items_sent >= CALM_AFTER) calm = 1'b1;
      end
      set_no++;
    end
    @(negedge clk_i);
    in_bus.valid <= 1'b0;

    while (sorted_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== lsd_radix_sort_decimal.f =====
+incdir+rtl
rtl/lsd_rsd_pkg.sv
rtl/lsd_rsd_in_if.sv
rtl/lsd_rsd_out_if.sv
rtl/lsd_rsd_front.sv
rtl/lsd_rsd_fifo.sv
rtl/lsd_rsd_back.sv
rtl/lsd_radix_sort_decimal.sv
tb/sv/tb_top.sv
